@@ hw/rtl/vtk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and code point constants for the VT key sequence decoder.
package vtk_pkg;

  localparam int CpW = 21;
  localparam int SymW = 4;
  localparam int MatchLen = 3;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CHAR = 2'd1,
    EV_PBEG = 2'd2,
    EV_PEND = 2'd3
  } event_kind_t;

  typedef enum logic [3:0] {
    KEY_CHAR    = 4'd0,
    KEY_UP      = 4'd1,
    KEY_DOWN    = 4'd2,
    KEY_RIGHT   = 4'd3,
    KEY_LEFT    = 4'd4,
    KEY_CRIGHT  = 4'd5,
    KEY_CLEFT   = 4'd6,
    KEY_HOME    = 4'd7,
    KEY_END     = 4'd8,
    KEY_BACKTAB = 4'd9,
    KEY_DELETE  = 4'd10
  } key_kind_t;

  localparam logic [SymW-1:0] SYM_SEMI = 4'd10;

  localparam logic [CpW-1:0] CP_TAB      = 21'h09;
  localparam logic [CpW-1:0] CP_LF       = 21'h0A;
  localparam logic [CpW-1:0] CP_CR       = 21'h0D;
  localparam logic [CpW-1:0] CP_ESC      = 21'h1B;
  localparam logic [CpW-1:0] CP_SPACE    = 21'h20;
  localparam logic [CpW-1:0] CP_ZERO     = 21'h30;
  localparam logic [CpW-1:0] CP_NINE     = 21'h39;
  localparam logic [CpW-1:0] CP_SEMI     = 21'h3B;
  localparam logic [CpW-1:0] CP_UPPER_A  = 21'h41;
  localparam logic [CpW-1:0] CP_UPPER_B  = 21'h42;
  localparam logic [CpW-1:0] CP_UPPER_C  = 21'h43;
  localparam logic [CpW-1:0] CP_UPPER_D  = 21'h44;
  localparam logic [CpW-1:0] CP_UPPER_F  = 21'h46;
  localparam logic [CpW-1:0] CP_UPPER_H  = 21'h48;
  localparam logic [CpW-1:0] CP_UPPER_O  = 21'h4F;
  localparam logic [CpW-1:0] CP_UPPER_Z  = 21'h5A;
  localparam logic [CpW-1:0] CP_LBRACKET = 21'h5B;
  localparam logic [CpW-1:0] CP_TILDE    = 21'h7E;

  typedef struct packed {
    logic            ctrl;
    logic            p200;
    logic            p201;
    logic            single;
    logic [SymW-1:0] first;
  } vtk_match_t;

endpackage

@@ hw/rtl/vtk_param_store.sv @@
`timescale 1ns / 1ps
// CSI parameter store with overflow flag and fixed-string matchers.
module vtk_param_store import vtk_pkg::*; #(
  parameter int PARAM_SLOTS = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            push,
  input  logic [SymW-1:0] sym,
  output vtk_match_t      match
);

  localparam int LenW = $clog2(PARAM_SLOTS + 1);

  logic [SymW-1:0] symbols [PARAM_SLOTS];
  logic [LenW-1:0] param_length;
  logic            param_overflow;
  logic            exact3;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      param_length   <= '0;
      param_overflow <= 1'b0;
    end else if (push) begin
      if (param_length < LenW'(PARAM_SLOTS)) begin
        param_length <= param_length + LenW'(1);
      end else begin
        param_overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PARAM_SLOTS; i++) begin
      if (push && !clear && param_length == LenW'(i)) begin
        symbols[i] <= sym;
      end
    end
  end

  assign exact3 = !param_overflow && param_length == LenW'(MatchLen);

  always_comb begin
    match.ctrl   = exact3 && symbols[0] == 4'd1 && symbols[1] == SYM_SEMI
                   && symbols[2] == 4'd5;
    match.p200   = exact3 && symbols[0] == 4'd2 && symbols[1] == 4'd0
                   && symbols[2] == 4'd0;
    match.p201   = exact3 && symbols[0] == 4'd2 && symbols[1] == 4'd0
                   && symbols[2] == 4'd1;
    match.single = !param_overflow && param_length == LenW'(1);
    match.first  = symbols[0];
  end

endmodule

@@ hw/rtl/vt_key_sequence_decoder_unit.sv @@
`timescale 1ns / 1ps
// VT key sequence decoder: turns terminal code points into characters, keys and paste events.
// One code point is accepted per cycle while the output side keeps up, and each yields exactly
// one result transaction, possibly with event_kind none. A code point is held in the input
// register, is decoded in a single pass against the parser state and the CSI parameter
// store when the output side is free, and is presented from the result register; one result
// per cycle is sustained while the output side keeps up.
module vt_key_sequence_decoder_unit import vtk_pkg::*; #(
  parameter int PARAM_SLOTS = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           code_valid,
  output logic           code_stall,
  input  logic [CpW-1:0] code_point,
  output logic           event_valid,
  input  logic           event_stall,
  output logic [1:0]     event_kind,
  output logic [3:0]     key_kind,
  output logic [CpW-1:0] char_value
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_SS3,
    PH_CSI
  } phase_t;

  phase_t          phase, phase_next;
  logic            paste_mode, paste_mode_next;
  logic            cr_seen, cr_seen_next;
  logic            code_full;
  logic [CpW-1:0]  cp;
  logic            out_free;
  logic            go;
  logic            clear_seq;
  logic            push_sym;
  logic [SymW-1:0] sym;
  vtk_match_t      match;
  event_kind_t     ev;
  key_kind_t       key;
  logic [CpW-1:0]  ch;

  assign out_free   = !event_valid || !event_stall;
  assign go         = code_full && out_free;
  assign code_stall = code_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_full <= 1'b0;
    end else if (code_valid && !code_stall) begin
      code_full <= 1'b1;
    end else if (go) begin
      code_full <= 1'b0;
    end
    if (code_valid && !code_stall) begin
      cp <= code_point;
    end
  end

  vtk_param_store #(
    .PARAM_SLOTS(PARAM_SLOTS)
  ) u_params (
    .clk   (clk),
    .rst   (rst),
    .clear (go && clear_seq),
    .push  (go && push_sym),
    .sym   (sym),
    .match (match)
  );

  always_comb begin
    phase_next      = phase;
    paste_mode_next = paste_mode;
    cr_seen_next    = cr_seen;
    clear_seq       = 1'b0;
    push_sym        = 1'b0;
    sym             = cp[SymW-1:0];
    ev              = EV_NONE;
    key             = KEY_CHAR;
    ch              = '0;
    case (phase)
      PH_ESC: begin
        if (cp == CP_LBRACKET) begin
          phase_next = PH_CSI;
          clear_seq  = 1'b1;
        end else if (cp == CP_UPPER_O) begin
          phase_next = PH_SS3;
        end else begin
          phase_next = PH_IDLE;
          clear_seq  = 1'b1;
          ev         = EV_CHAR;
          ch         = CP_ESC;
        end
      end
      PH_SS3: begin
        phase_next = PH_IDLE;
        clear_seq  = 1'b1;
        if (cp == CP_UPPER_H) begin
          ev  = EV_CHAR;
          key = KEY_HOME;
        end else if (cp == CP_UPPER_F) begin
          ev  = EV_CHAR;
          key = KEY_END;
        end
      end
      PH_CSI: begin
        if (cp >= CP_ZERO && cp <= CP_NINE) begin
          push_sym = 1'b1;
        end else if (cp == CP_SEMI) begin
          push_sym = 1'b1;
          sym      = SYM_SEMI;
        end else begin
          phase_next = PH_IDLE;
          clear_seq  = 1'b1;
          ev         = EV_CHAR;
          case (cp)
            CP_UPPER_A: key = KEY_UP;
            CP_UPPER_B: key = KEY_DOWN;
            CP_UPPER_C: key = match.ctrl ? KEY_CRIGHT : KEY_RIGHT;
            CP_UPPER_D: key = match.ctrl ? KEY_CLEFT : KEY_LEFT;
            CP_UPPER_H: key = KEY_HOME;
            CP_UPPER_F: key = KEY_END;
            CP_UPPER_Z: key = KEY_BACKTAB;
            CP_TILDE: begin
              if (match.p200) begin
                paste_mode_next = 1'b1;
                ev              = EV_PBEG;
              end else if (match.p201) begin
                paste_mode_next = 1'b0;
                ev              = EV_PEND;
              end else if (match.single && match.first inside {4'd1, 4'd5, 4'd7, 4'd8}) begin
                key = KEY_HOME;
              end else if (match.single && match.first == 4'd4) begin
                key = KEY_END;
              end else if (match.single && match.first == 4'd3) begin
                key = KEY_DELETE;
              end else begin
                ev = EV_NONE;
              end
            end
            default: ev = EV_NONE;
          endcase
        end
      end
      default: begin
        ev = EV_CHAR;
        ch = cp;
        if (paste_mode && cp == CP_CR) begin
          cr_seen_next = 1'b1;
          ch           = CP_LF;
        end else if (paste_mode && cp == CP_LF) begin
          cr_seen_next = 1'b0;
          if (cr_seen) begin
            ev = EV_NONE;
            ch = '0;
          end
        end else begin
          if (paste_mode) begin
            cr_seen_next = 1'b0;
          end
          if (paste_mode && cp == CP_TAB) begin
            ch = CP_SPACE;
          end else if (cp == CP_ESC) begin
            phase_next = PH_ESC;
            ev         = EV_NONE;
            ch         = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      paste_mode  <= 1'b0;
      cr_seen     <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      if (go) begin
        phase      <= phase_next;
        paste_mode <= paste_mode_next;
        cr_seen    <= cr_seen_next;
      end
      if (go) begin
        event_valid <= 1'b1;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
    if (go) begin
      event_kind <= ev;
      key_kind   <= key;
      char_value <= ch;
    end
  end

  a_key_implies_char: assert property (@(posedge clk) disable iff (rst)
    event_valid && key_kind != KEY_CHAR |-> event_kind == EV_CHAR && char_value == '0)
    else $error("key result carries a character or wrong event kind");

  a_char_needs_plain: assert property (@(posedge clk) disable iff (rst)
    event_valid && char_value != '0 |-> event_kind == EV_CHAR && key_kind == KEY_CHAR)
    else $error("character value on a non-character result");

  a_paste_begin: assert property (@(posedge clk) disable iff (rst)
    go && ev == EV_PBEG |=> paste_mode && event_kind == EV_PBEG)
    else $error("paste begin did not enter paste mode");

  a_paste_end: assert property (@(posedge clk) disable iff (rst)
    go && ev == EV_PEND |=> !paste_mode && phase == PH_IDLE)
    else $error("paste end did not leave paste mode");

endmodule
